@@ hdl/hfbe_pkg.sv @@
// Shared constants, types and the CRC step function for the HDLC frame bit encoder.
package hfbe_pkg;

  typedef logic [1:0] cmd_t;

  localparam cmd_t CMD_START  = 2'd0;
  localparam cmd_t CMD_DATA   = 2'd1;
  localparam cmd_t CMD_FLAG   = 2'd2;
  localparam cmd_t CMD_FOOTER = 2'd3;

  localparam int CRC_W   = 16;
  localparam int POS_W   = 16;
  localparam int BYTE_W  = 8;
  localparam int RUN_W   = 3;
  localparam int CNT_W   = $clog2(CRC_W + 1);
  localparam int FIDX_W  = $clog2(BYTE_W);

  localparam logic [CRC_W-1:0]  CRC_POLY     = 16'h8408;
  localparam logic [CRC_W-1:0]  CRC_PRESET   = 16'hFFFF;
  localparam logic [RUN_W-1:0]  STUFF_RUN    = 3'd5;
  localparam logic [BYTE_W-1:0] FLAG_PATTERN = 8'h7E;

  localparam logic [CNT_W-1:0]  CNT_BYTE   = CNT_W'(BYTE_W);
  localparam logic [CNT_W-1:0]  CNT_FOOTER = CNT_W'(CRC_W);

  typedef logic [CRC_W-1:0] crc_t;
  typedef logic [POS_W-1:0] pos_t;

  function automatic crc_t crc_step(input crc_t crc, input logic din);
    crc_t shifted;
    shifted = crc >> 1;
    if (crc[0] ^ din) begin
      return shifted ^ CRC_POLY;
    end
    return shifted;
  endfunction

endpackage

@@ hdl/hfbe_if.sv @@
// Valid/ready channel interfaces for frame commands and emitted line bits.
interface hfbe_cmd_if;
  logic             valid;
  logic             ready;
  hfbe_pkg::cmd_t   command;
  logic [7:0]       data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface hfbe_bit_if;
  logic             valid;
  logic             ready;
  logic             line_bit;
  hfbe_pkg::pos_t   bit_position;
  logic             last_of_run;

  modport source (output valid, output line_bit, output bit_position, output last_of_run,
                  input ready);
  modport sink   (input valid, input line_bit, input bit_position, input last_of_run,
                  output ready);
endinterface

@@ hdl/hdlc_frame_bit_encoder.sv @@
// HDLC/AX.25 frame bit encoder: one command beat in, one line bit per output beat.
// A command is accepted only while the encoder is idle; then it produces one bit
// per cycle through a single bit-serial CRC/stuffing step, as long as the output
// register is free: a data byte yields 8 to 10 line bits, a flag 8, a footer 24
// to 28, and a start command none. The sequencer is ready for the next command
// once the last bit of the current one has entered the output register, so the
// input takes no command while a data byte is encoded. Bit positions wrap at 65536.
module hdlc_frame_bit_encoder (
  input  logic       clk,
  input  logic       rst,
  hfbe_cmd_if.sink   cmd,
  hfbe_bit_if.source bits
);
  import hfbe_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DATA = 2'd1;
  localparam logic [1:0] ST_FLAG = 2'd2;

  logic [1:0]        state, state_next;
  logic              flag_after, flag_after_next;
  logic              stuff_pend, stuff_pend_next;
  logic [CRC_W-1:0]  sr, sr_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [FIDX_W-1:0] fidx, fidx_next;
  crc_t              crc, crc_next;
  logic [RUN_W-1:0]  run, run_next;
  pos_t              bit_counter, bit_counter_next;
  logic              o_valid, o_valid_next;
  logic              o_bit, o_bit_next;
  pos_t              o_pos, o_pos_next;
  logic              o_last, o_last_next;

  logic emit_en;
  logic emit;
  logic ebit;
  logic elast;
  logic stuff_now;

  assign cmd.ready         = (state == ST_IDLE);
  assign bits.valid        = o_valid;
  assign bits.line_bit     = o_bit;
  assign bits.bit_position = o_pos;
  assign bits.last_of_run  = o_last;

  assign emit_en = (state != ST_IDLE) && (!o_valid || bits.ready);

  always_comb begin
    state_next       = state;
    flag_after_next  = flag_after;
    stuff_pend_next  = stuff_pend;
    sr_next          = sr;
    cnt_next         = cnt;
    fidx_next        = fidx;
    crc_next         = crc;
    run_next         = run;
    bit_counter_next = bit_counter;
    o_valid_next     = o_valid && !bits.ready;
    o_bit_next       = o_bit;
    o_pos_next       = o_pos;
    o_last_next      = o_last;
    emit             = 1'b0;
    ebit             = 1'b0;
    elast            = 1'b0;
    stuff_now        = 1'b0;

    case (state)
      ST_IDLE: begin
        if (cmd.valid) begin
          case (cmd.command)
            CMD_START: begin
              crc_next         = CRC_PRESET;
              run_next         = '0;
              bit_counter_next = '0;
            end
            CMD_DATA: begin
              sr_next         = {{(CRC_W-BYTE_W){1'b0}}, cmd.data_byte};
              cnt_next        = CNT_BYTE;
              flag_after_next = 1'b0;
              stuff_pend_next = 1'b0;
              state_next      = ST_DATA;
            end
            CMD_FLAG: begin
              fidx_next       = '0;
              flag_after_next = 1'b1;
              state_next      = ST_FLAG;
            end
            default: begin
              sr_next         = ~crc;
              cnt_next        = CNT_FOOTER;
              flag_after_next = 1'b1;
              stuff_pend_next = 1'b0;
              fidx_next       = '0;
              state_next      = ST_DATA;
            end
          endcase
        end
      end
      ST_DATA: begin
        if (emit_en) begin
          emit = 1'b1;
          if (stuff_pend) begin
            ebit            = 1'b0;
            stuff_pend_next = 1'b0;
            if (cnt == '0) begin
              elast      = !flag_after;
              state_next = flag_after ? ST_FLAG : ST_IDLE;
            end
          end else begin
            ebit      = sr[0];
            crc_next  = crc_step(crc, sr[0]);
            sr_next   = sr >> 1;
            cnt_next  = cnt - CNT_W'(1);
            stuff_now = sr[0] && (run == STUFF_RUN - RUN_W'(1));
            if (sr[0]) begin
              run_next = stuff_now ? '0 : run + RUN_W'(1);
            end else begin
              run_next = '0;
            end
            stuff_pend_next = stuff_now;
            if ((cnt == CNT_W'(1)) && !stuff_now) begin
              elast      = !flag_after;
              state_next = flag_after ? ST_FLAG : ST_IDLE;
            end
          end
        end
      end
      ST_FLAG: begin
        if (emit_en) begin
          emit      = 1'b1;
          ebit      = FLAG_PATTERN[fidx];
          elast     = (fidx == FIDX_W'(BYTE_W - 1));
          fidx_next = fidx + FIDX_W'(1);
          run_next  = '0;
          if (elast) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (emit) begin
      o_valid_next     = 1'b1;
      o_bit_next       = ebit;
      o_pos_next       = bit_counter;
      o_last_next      = elast;
      bit_counter_next = bit_counter + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      flag_after  <= 1'b0;
      stuff_pend  <= 1'b0;
      cnt         <= '0;
      fidx        <= '0;
      crc         <= CRC_PRESET;
      run         <= '0;
      bit_counter <= '0;
      o_valid     <= 1'b0;
    end else begin
      state       <= state_next;
      flag_after  <= flag_after_next;
      stuff_pend  <= stuff_pend_next;
      cnt         <= cnt_next;
      fidx        <= fidx_next;
      crc         <= crc_next;
      run         <= run_next;
      bit_counter <= bit_counter_next;
      o_valid     <= o_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    sr     <= sr_next;
    o_bit  <= o_bit_next;
    o_pos  <= o_pos_next;
    o_last <= o_last_next;
  end

endmodule

@@ hdl/hfbe_checker.sv @@
// Port-level checker for the HDLC frame bit encoder, with its bind statement.
module hfbe_port_checker (
  input logic        clk,
  input logic        rst,
  input logic        cmd_valid,
  input logic        cmd_ready,
  input logic        bits_valid,
  input logic        bits_ready,
  input logic        bits_line_bit,
  input logic [15:0] bits_position,
  input logic        bits_last
);
  logic        run_open;
  logic [15:0] prev_pos;
  logic        bits_acc;
  logic        cmd_acc;

  assign bits_acc = bits_valid && bits_ready;
  assign cmd_acc  = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_open <= 1'b0;
      prev_pos <= '0;
    end else if (bits_acc) begin
      run_open <= !bits_last;
      prev_pos <= bits_position;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    bits_valid && !bits_ready |=> bits_valid && $stable(bits_position)
      && $stable(bits_line_bit) && $stable(bits_last))
    else $error("output beat changed while stalled");

  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    bits_acc && run_open |-> bits_position == prev_pos + 16'd1)
    else $error("bit position did not advance by one within a run");

  a_cmd_after_last: assert property (@(posedge clk) disable iff (rst)
    cmd_acc && run_open |-> bits_valid && bits_last)
    else $error("command taken before the current run ended");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !bits_valid)
    else $error("output beat valid right after reset");

endmodule

bind hdlc_frame_bit_encoder hfbe_port_checker u_hfbe_port_checker (
  .clk          (clk),
  .rst          (rst),
  .cmd_valid    (cmd.valid),
  .cmd_ready    (cmd.ready),
  .bits_valid   (bits.valid),
  .bits_ready   (bits.ready),
  .bits_line_bit(bits.line_bit),
  .bits_position(bits.bit_position),
  .bits_last    (bits.last_of_run)
);
